>>> hdl/assert_macros.svh
// Assertion macros shared by the mask assembly RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define SMA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/sma_pkg.sv
// Package for the segmentation mask assembly block: item types, opcodes, sigmoid table.
// No dependencies.
`timescale 1ns / 1ps

package sma_pkg;

    localparam int FIELD_LANES = 8;
    localparam int GROUPS      = 4;
    localparam int SUM_W       = 35;   // sum of eight Q16.16 products
    localparam int ACC_W       = 36;   // sum plus carried partial

    localparam logic [1:0] OP_COEF   = 2'd0;
    localparam logic [1:0] OP_BOX    = 2'd1;
    localparam logic [1:0] OP_PIXEL  = 2'd2;
    localparam logic [1:0] GRP_FIRST = 2'd0;
    localparam logic [1:0] GRP_LAST  = 2'd3;

    localparam logic signed [31:0] SUM_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SUM_MIN   = -32'sh7FFF_FFFF - 32'sd1;
    localparam logic signed [31:0] SIG_LIMIT = 32'sd524288;   // 8.0 in Q16.16

    typedef logic signed [31:0] t_prod;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         group;
        logic [7:0]         px;
        logic [7:0]         py;
        logic signed [15:0] v0;
        logic signed [15:0] v1;
        logic signed [15:0] v2;
        logic signed [15:0] v3;
        logic signed [15:0] v4;
        logic signed [15:0] v5;
        logic signed [15:0] v6;
        logic signed [15:0] v7;
    } t_in_item;

    typedef struct packed {
        logic [7:0] mask_value;
        logic [7:0] out_x;
        logic [7:0] out_y;
        logic       inside_box;
    } t_out_item;

    // Pixel item leaving the lane stage
    typedef struct packed {
        logic       valid;
        logic [1:0] grp;
        logic [7:0] px;
        logic [7:0] py;
        logic       in_box;
    } t_s1;

    // Finished pixel waiting for the sigmoid stage
    typedef struct packed {
        logic       valid;
        logic [7:0] px;
        logic [7:0] py;
        logic       in_box;
    } t_s3;

    // round(255 * sigmoid(midpoint)) over -8..8 in steps of 1/4
    localparam logic [7:0] SIG_TABLE [64] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd3,   8'd4,
        8'd5,   8'd7,   8'd8,   8'd11,  8'd14,  8'd17,  8'd22,  8'd27,
        8'd34,  8'd42,  8'd51,  8'd62,  8'd75,  8'd89,  8'd104, 8'd120,
        8'd135, 8'd151, 8'd166, 8'd180, 8'd193, 8'd204, 8'd213, 8'd221,
        8'd228, 8'd233, 8'd238, 8'd241, 8'd244, 8'd247, 8'd248, 8'd250,
        8'd251, 8'd252, 8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254,
        8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
    };

endpackage

>>> hdl/sma_stream_if.sv
// Valid/ready stream interface, payload type set per instance.
// No dependencies.
`timescale 1ns / 1ps

interface sma_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/sma_lane.sv
// One multiply lane: holds its coefficient per group and registers coef * prototype.
// Depends on sma_pkg.
`timescale 1ns / 1ps

module sma_lane import sma_pkg::*; #(
    parameter int LANE     = 0,
    parameter int LANES    = 8,
    parameter int CHANNELS = 32
) (
    input  logic               i_clk,
    input  logic               i_wr,
    input  logic               i_ld,
    input  logic [1:0]         i_grp,
    input  logic signed [15:0] i_val,
    output t_prod              o_prod
);

    logic signed [15:0] r_coef [GROUPS];
    t_prod              r_prod;
    logic               idx_ok;
    logic signed [15:0] coef;

    // channel index past the coefficient count is dropped on write, zero on read
    assign idx_ok = ((int'(i_grp) * LANES) + LANE) < CHANNELS;
    assign coef   = idx_ok ? r_coef[i_grp] : 16'sd0;

    always_ff @(posedge i_clk) begin
        if (i_wr && idx_ok) begin
            r_coef[i_grp] <= i_val;
        end
        if (i_ld) begin
            r_prod <= coef * i_val;
        end
    end

    assign o_prod = r_prod;

endmodule

>>> hdl/sma_box_axis.sv
// One axis of the box: clamps start/end to the image, then writes quarter-grid bounds.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module sma_box_axis #(
    parameter int LIMIT = 640
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_ld,
    input  logic                               i_commit,
    input  logic signed [15:0]                 i_start,
    input  logic signed [15:0]                 i_len,
    output logic [$clog2(LIMIT/4+1)-1:0]       o_lo,
    output logic [$clog2(LIMIT/4+1)-1:0]       o_hi
);

    localparam int AW = $clog2(LIMIT + 1);
    localparam int BW = $clog2(LIMIT/4 + 1);
    localparam logic signed [17:0] LIM = 18'(LIMIT);

    logic signed [17:0] start_x, end_x, end_cap, a18, diff, w;
    logic [AW-1:0]      a_clamp;
    logic [AW-1:0]      r_a;
    logic signed [17:0] r_b;
    logic [BW-1:0]      r_lo, r_hi;

    // first step: clamp start, cap end
    always_comb begin
        start_x = 18'(i_start);
        end_x   = 18'(i_start) + 18'(i_len);
        if (start_x < 18'sd0) begin
            a_clamp = '0;
        end else if (start_x > LIM) begin
            a_clamp = AW'(LIMIT);
        end else begin
            a_clamp = start_x[AW-1:0];
        end
        end_cap = (end_x > LIM) ? LIM : end_x;
    end

    // second step: scale down by four
    always_comb begin
        a18  = 18'(r_a);
        diff = r_b - a18;
        w    = (r_b > a18) ? (diff >>> 2) : 18'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_a <= a_clamp;
            r_b <= end_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_commit) begin
            r_lo <= BW'(r_a >> 2);
            r_hi <= BW'(18'(r_a >> 2) + w);
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

>>> hdl/sma_merge.sv
// Merge stages: sums the lane products, then accumulates and saturates the partial sum.
// Depends on sma_pkg.
`timescale 1ns / 1ps

module sma_merge import sma_pkg::*; #(
    parameter int NL = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_s1         i_s1,
    input  t_prod       i_prod [NL],
    input  logic        i_rdy4,
    output logic        o_rdy2,
    output t_s3         o_s3,
    output logic signed [31:0] o_sum
);

    logic                    r_v2, r_v3;
    logic [1:0]              r_grp;
    logic [7:0]              r_px2, r_py2, r_px3, r_py3;
    logic                    r_in2, r_in3;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [31:0]      r_partial;
    logic signed [SUM_W-1:0] lane_sum;
    logic signed [ACC_W-1:0] acc;
    logic signed [31:0]      n_partial;
    logic                    rdy3;

    assign rdy3   = !r_v3 || i_rdy4;
    assign o_rdy2 = !r_v2 || rdy3;

    // lane products added in one registered level
    always_comb begin
        lane_sum = '0;
        for (int i = 0; i < NL; i++) begin
            lane_sum = lane_sum + SUM_W'(i_prod[i]);
        end
    end

    // first group restarts the sum; saturate to 32 bits
    always_comb begin
        acc = ((r_grp == GRP_FIRST) ? '0 : ACC_W'(r_partial)) + ACC_W'(r_sum);
        if (acc > ACC_W'(SUM_MAX)) begin
            n_partial = SUM_MAX;
        end else if (acc < ACC_W'(SUM_MIN)) begin
            n_partial = SUM_MIN;
        end else begin
            n_partial = acc[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_partial <= '0;
        end else begin
            if (o_rdy2) begin
                r_v2 <= i_s1.valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2 && (r_grp == GRP_LAST);
                if (r_v2) begin
                    r_partial <= n_partial;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy2) begin
            r_grp <= i_s1.grp;
            r_px2 <= i_s1.px;
            r_py2 <= i_s1.py;
            r_in2 <= i_s1.in_box;
            r_sum <= lane_sum;
        end
        if (rdy3) begin
            r_px3 <= r_px2;
            r_py3 <= r_py2;
            r_in3 <= r_in2;
        end
    end

    assign o_s3.valid  = r_v3;
    assign o_s3.px     = r_px3;
    assign o_s3.py     = r_py3;
    assign o_s3.in_box = r_in3;
    assign o_sum       = r_partial;

endmodule

>>> hdl/segmentation_mask_assembly.sv
// Top level of the segmentation mask assembly block.
// Depends on sma_pkg, sma_stream_if, sma_lane, sma_box_axis, sma_merge, assert_macros.svh.
//
//   port    | dir | payload     | meaning
//   i_in    | in  | t_in_item   | coefficient load, box load, prototype pixel group
//   o_out   | out | t_out_item  | one mask value per pixel, on its last group
//
// One item per cycle unless the output stalls; an item passes through the lane multiply,
// lane sum, accumulate and sigmoid/output register stages before its result leaves.
// The accumulate register closes the only feedback loop.
// Synchronous active-low reset empties the pipe and clears box and partial sum.
// Stages only hold when the stage ahead is full, so bubbles collapse under stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module segmentation_mask_assembly import sma_pkg::*; #(
    parameter int INPUT_WIDTH  = 640,
    parameter int INPUT_HEIGHT = 640,
    parameter int CHANNELS     = 32,
    parameter int LANES        = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sma_stream_if.sink    i_in,
    sma_stream_if.source  o_out
);

    localparam int NL  = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
    localparam int XBW = $clog2(INPUT_WIDTH/4 + 1);
    localparam int YBW = $clog2(INPUT_HEIGHT/4 + 1);
    localparam int MBW = (XBW > YBW) ? XBW : YBW;
    localparam int CW  = (MBW > 8) ? MBW : 8;

    t_in_item           in_d;
    logic               accept, ready1, rdy2, rdy4, commit;
    logic signed [15:0] lane_v [FIELD_LANES];
    t_prod              prod [NL];
    logic [XBW-1:0]     x_lo, x_hi;
    logic [YBW-1:0]     y_lo, y_hi;
    t_s1                s1;
    t_s3                s3;
    logic signed [31:0] sum;

    logic               r_v1, r_is_box, r_is_pix;
    logic [1:0]         r_grp;
    logic [7:0]         r_px, r_py;
    logic               r_v4;
    t_out_item          r_out;
    logic [7:0]         sig;
    logic signed [31:0] sig_off;

    assign in_d       = i_in.data;
    assign accept     = i_in.valid && ready1;
    assign ready1     = !r_v1 || rdy2;
    assign i_in.ready = ready1;

    assign lane_v[0] = in_d.v0;
    assign lane_v[1] = in_d.v1;
    assign lane_v[2] = in_d.v2;
    assign lane_v[3] = in_d.v3;
    assign lane_v[4] = in_d.v4;
    assign lane_v[5] = in_d.v5;
    assign lane_v[6] = in_d.v6;
    assign lane_v[7] = in_d.v7;

    // multiply lanes
    for (genvar l = 0; l < NL; l++) begin : g_lane
        sma_lane #(
            .LANE     (l),
            .LANES    (LANES),
            .CHANNELS (CHANNELS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_wr   (accept && (in_d.op == OP_COEF)),
            .i_ld   (accept),
            .i_grp  (in_d.group),
            .i_val  (lane_v[l]),
            .o_prod (prod[l])
        );
    end

    // stage 1 item tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ready1) begin
            r_v1 <= accept && ((in_d.op == OP_BOX) || (in_d.op == OP_PIXEL));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_box <= (in_d.op == OP_BOX);
            r_is_pix <= (in_d.op == OP_PIXEL);
            r_grp    <= in_d.group;
            r_px     <= in_d.px;
            r_py     <= in_d.py;
        end
    end

    // box bounds update as the box item leaves stage 1
    assign commit = r_v1 && r_is_box && rdy2;

    sma_box_axis #(.LIMIT(INPUT_WIDTH)) u_box_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ld     (accept && (in_d.op == OP_BOX)),
        .i_commit (commit),
        .i_start  (in_d.v0),
        .i_len    (in_d.v2),
        .o_lo     (x_lo),
        .o_hi     (x_hi)
    );

    sma_box_axis #(.LIMIT(INPUT_HEIGHT)) u_box_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ld     (accept && (in_d.op == OP_BOX)),
        .i_commit (commit),
        .i_start  (in_d.v1),
        .i_len    (in_d.v3),
        .o_lo     (y_lo),
        .o_hi     (y_hi)
    );

    // box test against bounds in force at this item's turn
    assign s1.valid  = r_v1 && r_is_pix;
    assign s1.grp    = r_grp;
    assign s1.px     = r_px;
    assign s1.py     = r_py;
    assign s1.in_box = (CW'(r_px) >= CW'(x_lo)) && (CW'(r_px) < CW'(x_hi)) &&
                       (CW'(r_py) >= CW'(y_lo)) && (CW'(r_py) < CW'(y_hi));

    sma_merge #(.NL(NL)) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .i_prod  (prod),
        .i_rdy4  (rdy4),
        .o_rdy2  (rdy2),
        .o_s3    (s3),
        .o_sum   (sum)
    );

    // sigmoid lookup, saturating beyond +/-8
    assign sig_off = sum + SIG_LIMIT;
    always_comb begin
        if (sum <= -SIG_LIMIT) begin
            sig = 8'd0;
        end else if (sum >= SIG_LIMIT) begin
            sig = 8'd255;
        end else begin
            sig = SIG_TABLE[sig_off[19:14]];
        end
    end

    // output register
    assign rdy4 = !r_v4 || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= s3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_out.mask_value <= s3.in_box ? sig : 8'd0;
            r_out.out_x      <= s3.px;
            r_out.out_y      <= s3.py;
            r_out.inside_box <= s3.in_box;
        end
    end

    assign o_out.valid = r_v4;
    assign o_out.data  = r_out;

    // checks
    `SMA_ASSERT(a_zero_outside, o_out.valid && !o_out.data.inside_box |-> o_out.data.mask_value == 8'd0, "mask value nonzero outside box")
    `SMA_ASSERT(a_stall_full, !i_in.ready |-> r_v4 && !o_out.ready && s3.valid, "input stalled with a free stage")
    `SMA_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out.valid, "result valid after reset")

endmodule
